// ===== sv/ura_pkg.sv =====
// Shared types and constants for the ultrasonic range averager.
// Used by ura_ranger, ura_averager and ultrasonic_range_averager_core.
package ura_pkg;

	localparam int CM_W       = 10;
	localparam int TIMER_W    = 24;
	localparam int TRIG_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam int TICKS_PER_CM_DEF = 58;
	localparam int AVERAGE_LOG2_DEF = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_ECHO_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CM        = 2'd3;

	localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 16'd1000;
	localparam logic [TIMER_W-1:0] SETTLE_TICKS_RST  = 24'd62000;
	localparam logic [TIMER_W-1:0] NO_ECHO_LIMIT_RST = 24'd458752;
	localparam logic [CM_W-1:0]    MAX_CM_RST        = 10'd400;

	typedef enum logic [1:0] {
		PH_TRIGGER = 2'd0,
		PH_WAIT    = 2'd1,
		PH_SETTLE  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [TRIG_W-1:0]  trigger_ticks;
		logic [TIMER_W-1:0] settle_ticks;
		logic [TIMER_W-1:0] no_echo_limit;
		logic [CM_W-1:0]    max_cm;
	} cfg_t;

	typedef struct packed {
		logic            trigger;
		logic            done;
		logic [CM_W-1:0] cm;
	} sample_t;

	typedef struct packed {
		logic            valid;
		logic [CM_W-1:0] value;
	} read_t;

endpackage

// ===== sv/ura_ranger.sv =====
// Trigger, echo timing and timeout sequencer of the range averager.
// Depends on ura_pkg; the echo width is kept as a quotient and remainder of TICKS_PER_CM.
module ura_ranger #(
	parameter int TICKS_PER_CM = ura_pkg::TICKS_PER_CM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              echo,
	input  ura_pkg::cfg_t     cfg,
	output ura_pkg::sample_t  res
);

	localparam int RW  = (TICKS_PER_CM > 1) ? $clog2(TICKS_PER_CM) : 1;
	localparam int Q_W = ura_pkg::CM_W + 1;
	localparam logic [Q_W-1:0] QSAT = Q_W'(1 << ura_pkg::CM_W);
	localparam logic [RW:0]    RWRAP = (RW + 1)'(TICKS_PER_CM);

	ura_pkg::phase_t phase_q, phase_d;
	logic [ura_pkg::TIMER_W-1:0] timer_q, timer_d, timer_inc;
	logic                        started_q, started_d;
	logic [Q_W-1:0]              quot_q, quot_d;
	logic [RW-1:0]               rem_q, rem_d;
	logic                        prev_q;
	logic [RW:0]                 rem_inc;
	logic                        rise, hold_high, fall, timeout;
	logic [ura_pkg::TRIG_W-1:0]  trig_len;
	logic [ura_pkg::CM_W-1:0]    cm_meas;

	// Output logic: what this tick shows, from the state at its start.
	always_comb begin
		timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
		rise      = echo && !prev_q;
		hold_high = echo && prev_q && started_q;
		fall      = !echo && prev_q && started_q;
		timeout   = timer_inc >= cfg.no_echo_limit;
		cm_meas   = (quot_q > {1'b0, cfg.max_cm}) ? cfg.max_cm : quot_q[ura_pkg::CM_W-1:0];
		trig_len  = (cfg.trigger_ticks == '0) ? ura_pkg::TRIG_W'(1) : cfg.trigger_ticks;
		res       = '0;
		case (phase_q)
			ura_pkg::PH_WAIT: begin
				res.done = fall || timeout;
				res.cm   = fall ? cm_meas : (timeout ? cfg.max_cm : '0);
			end
			ura_pkg::PH_SETTLE: begin
				res.trigger = 1'b0;
			end
			default: begin
				res.trigger = 1'b1;
			end
		endcase
	end

	// Next-state logic.
	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_inc;
		started_d = started_q;
		quot_d    = quot_q;
		rem_d     = rem_q;
		rem_inc   = {1'b0, rem_q} + 1'b1;
		case (phase_q)
			ura_pkg::PH_WAIT: begin
				if (res.done) begin
					started_d = 1'b0;
					quot_d    = '0;
					rem_d     = '0;
					timer_d   = '0;
					phase_d   = (cfg.settle_ticks == '0) ? ura_pkg::PH_TRIGGER
						: ura_pkg::PH_SETTLE;
				end else if (rise) begin
					started_d = 1'b1;
					quot_d    = (TICKS_PER_CM == 1) ? Q_W'(1) : '0;
					rem_d     = (TICKS_PER_CM == 1) ? '0 : RW'(1);
				end else if (hold_high && quot_q != QSAT) begin
					// Once the quotient passes any clamp value it stops counting.
					if (rem_inc == RWRAP) begin
						rem_d  = '0;
						quot_d = quot_q + 1'b1;
					end else begin
						rem_d = rem_inc[RW-1:0];
					end
				end
			end
			ura_pkg::PH_SETTLE: begin
				if (timer_inc >= cfg.settle_ticks) begin
					phase_d = ura_pkg::PH_TRIGGER;
					timer_d = '0;
				end
			end
			default: begin
				if (timer_inc >= {{(ura_pkg::TIMER_W - ura_pkg::TRIG_W){1'b0}}, trig_len}) begin
					phase_d   = ura_pkg::PH_WAIT;
					timer_d   = '0;
					started_d = 1'b0;
					quot_d    = '0;
					rem_d     = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ura_pkg::PH_TRIGGER;
			timer_q   <= '0;
			started_q <= 1'b0;
			quot_q    <= '0;
			rem_q     <= '0;
			prev_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			started_q <= started_d;
			quot_q    <= quot_d;
			rem_q     <= rem_d;
			prev_q    <= echo;
		end
	end

`ifndef SYNTHESIS
	a_done_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> phase_q == ura_pkg::PH_WAIT)
		else $error("sample taken outside the echo wait");
	a_cm_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> res.cm <= cfg.max_cm)
		else $error("sample above the clamp value");
	a_done_leaves_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done |=> phase_q != ura_pkg::PH_WAIT && timer_q == '0)
		else $error("echo wait did not end after a sample");
`endif

endmodule

// ===== sv/ura_averager.sv =====
// Sample accumulator, stored average and read-and-clear logic.
// Depends on ura_pkg; averages 2**AVERAGE_LOG2 samples.
module ura_averager #(
	parameter int AVERAGE_LOG2 = ura_pkg::AVERAGE_LOG2_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              read_request,
	input  ura_pkg::sample_t  sample,
	output ura_pkg::read_t    rd
);

	localparam int SUM_W = ura_pkg::CM_W + AVERAGE_LOG2;
	localparam int CNT_W = AVERAGE_LOG2 + 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(2 ** AVERAGE_LOG2);

	logic [SUM_W-1:0]          sum_q, sum_new;
	logic [CNT_W-1:0]          count_q, count_new;
	logic [ura_pkg::CM_W-1:0]  avg_q;
	logic                      full;

	always_comb begin
		rd.valid  = read_request && (avg_q != '0);
		rd.value  = rd.valid ? avg_q : '0;
		sum_new   = sum_q + SUM_W'(sample.cm);
		count_new = count_q + 1'b1;
		full      = sample.done && (count_new == CNT_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			avg_q   <= '0;
		end else if (step) begin
			// A read clears first, so an average stored on the same tick survives.
			if (full) begin
				avg_q <= sum_new[SUM_W-1 -: ura_pkg::CM_W];
			end else if (rd.valid) begin
				avg_q <= '0;
			end
			if (full) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (sample.done) begin
				sum_q   <= sum_new;
				count_q <= count_new;
			end
		end
	end

`ifndef SYNTHESIS
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && rd.valid && !full |=> avg_q == '0)
		else $error("stored average not cleared by a read");
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_FULL)
		else $error("sample count beyond the averaging window");
	a_idle_keeps_average: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(avg_q))
		else $error("stored average changed without a transfer");
`endif

endmodule

// ===== sv/ultrasonic_range_averager_core.sv =====
// Top level of the ultrasonic range averager: handshakes, configuration registers, result register.
// Depends on ura_pkg, ura_ranger and ura_averager.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   echo, read_request
//   out      output     out_valid / out_stall trigger, sample_done, sample_cm,
//                                             read_valid, read_value
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// Each tick item passes an input register, then one pass of sequencer and averager logic into
// the result register; one item per cycle is sustained while out_stall is low.
// The input register keeps taking items while a result waits, as long as the result register
// will be free on the next edge; out_stall holds the pipeline and the sequencer state.
// Reset puts the sequencer in the trigger phase with all counters and the average cleared.
module ultrasonic_range_averager_core #(
	parameter int TICKS_PER_CM = ura_pkg::TICKS_PER_CM_DEF,
	parameter int AVERAGE_LOG2 = ura_pkg::AVERAGE_LOG2_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             echo,
	input  logic                             read_request,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             trigger,
	output logic                             sample_done,
	output logic [ura_pkg::CM_W-1:0]         sample_cm,
	output logic                             read_valid,
	output logic [ura_pkg::CM_W-1:0]         read_value,
	input  logic                             cfg_write,
	input  logic [ura_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ura_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ura_pkg::cfg_t     cfg_q;
	ura_pkg::sample_t  sample;
	ura_pkg::read_t    rd;

	logic valid_s1, echo_s1, read_s1;
	logic out_valid_q;
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks <= ura_pkg::TRIGGER_TICKS_RST;
			cfg_q.settle_ticks  <= ura_pkg::SETTLE_TICKS_RST;
			cfg_q.no_echo_limit <= ura_pkg::NO_ECHO_LIMIT_RST;
			cfg_q.max_cm        <= ura_pkg::MAX_CM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ura_pkg::REG_TRIGGER_TICKS: cfg_q.trigger_ticks <= cfg_data[ura_pkg::TRIG_W-1:0];
				ura_pkg::REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_data;
				ura_pkg::REG_NO_ECHO_LIMIT: cfg_q.no_echo_limit <= cfg_data;
				ura_pkg::REG_MAX_CM:        cfg_q.max_cm        <= cfg_data[ura_pkg::CM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			echo_s1 <= echo;
			read_s1 <= read_request;
		end
	end

	ura_ranger #(
		.TICKS_PER_CM(TICKS_PER_CM)
	) u_ranger (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.echo   (echo_s1),
		.cfg    (cfg_q),
		.res    (sample)
	);

	ura_averager #(
		.AVERAGE_LOG2(AVERAGE_LOG2)
	) u_averager (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.read_request (read_s1),
		.sample       (sample),
		.rd           (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trigger     <= sample.trigger;
			sample_done <= sample.done;
			sample_cm   <= sample.cm;
			read_valid  <= rd.valid;
			read_value  <= rd.value;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/ultrasonic_range_averager_core_tb.sv =====
// Testbench for ultrasonic_range_averager_core: streams echo ticks through the valid/stall
// channels under several register settings and checks each result against a tick predictor or a typed expected value.
// Depends on ura_pkg and the RTL of ultrasonic_range_averager_core.
module ultrasonic_range_averager_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                     trigger;
		logic                     sample_done;
		logic [ura_pkg::CM_W-1:0] sample_cm;
		logic                     read_valid;
		logic [ura_pkg::CM_W-1:0] read_value;
	} tick_result_t;

	typedef enum logic {ROW_TICK, ROW_SETTINGS} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		ura_pkg::cfg_t  settings;
		logic           echo_level;
		logic           read_req;
		bit             typed;
		tick_result_t   want;
	} dir_row_t;

	typedef struct {
		ura_pkg::cfg_t settings;
		int            ticks;
		bit            long_echo;
		bit            hold_off;
	} run_phase_t;

	localparam int SUM_W = ura_pkg::CM_W + ura_pkg::AVERAGE_LOG2_DEF;
	localparam int unsigned LONG_ECHO_TICKS = 180;
	localparam tick_result_t TRIG_ONLY   = '{1'b1, 1'b0, 10'd0, 1'b0, 10'd0};
	localparam tick_result_t SAMPLE_ZERO = '{1'b0, 1'b1, 10'd0, 1'b0, 10'd0};
	localparam logic [ura_pkg::TIMER_W-1:0] TIMER_MAX = '1;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           echo;
	logic                           read_request;
	logic                           out_valid;
	logic                           out_stall;
	logic                           trigger;
	logic                           sample_done;
	logic [ura_pkg::CM_W-1:0]       sample_cm;
	logic                           read_valid;
	logic [ura_pkg::CM_W-1:0]       read_value;
	logic                           cfg_write;
	logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ura_pkg::CFG_DATA_W-1:0] cfg_data;

	ultrasonic_range_averager_core dut (.*);

	// Predictor state of the ranger and averager.
	ura_pkg::cfg_t                      range_cfg;
	ura_pkg::phase_t                    ph;
	logic [ura_pkg::TIMER_W-1:0]        ph_timer;
	logic                               echo_armed;
	logic [ura_pkg::TIMER_W-1:0]        echo_ticks;
	logic                               echo_prev;
	logic [SUM_W-1:0]                   cm_sum;
	logic [ura_pkg::AVERAGE_LOG2_DEF:0] cm_count;
	logic [ura_pkg::CM_W-1:0]           avg_held;

	tick_result_t tick_outputs_due[$];
	int           bad_ticks;
	int           burst_left;
	bit           hold_off_req;
	bit           finishing;

	// Echo waveform generator state.
	int unsigned  pulse_left;
	int unsigned  lead_left;
	bit           wait_seen;
	bit           pulse_fired;
	bit           long_echo_due;
	bit           quiet;

	dir_row_t     dir_rows[$];
	run_phase_t   plan[6];

	function automatic logic [ura_pkg::TIMER_W-1:0] sat_inc(logic [ura_pkg::TIMER_W-1:0] v);
		return (v == TIMER_MAX) ? v : v + 1'b1;
	endfunction

	function automatic tick_result_t ranger_tick(logic e, logic rd);
		tick_result_t                r;
		logic [ura_pkg::TIMER_W-1:0] trig_len;
		logic [ura_pkg::TIMER_W-1:0] width_cm;
		logic                        complete;
		r = '0;
		complete = 1'b0;
		// The read sees the average held at the start of the tick.
		if (rd && avg_held != '0) begin
			r.read_valid = 1'b1;
			r.read_value = avg_held;
			avg_held = '0;
		end
		case (ph)
		ura_pkg::PH_WAIT: begin
			ph_timer = sat_inc(ph_timer);
			if (e && !echo_prev) begin
				echo_armed = 1'b1;
				echo_ticks = ura_pkg::TIMER_W'(1);
			end else if (e && echo_armed) begin
				echo_ticks = sat_inc(echo_ticks);
			end else if (!e && echo_prev && echo_armed) begin
				complete = 1'b1;
			end
			// A completed echo wins over the timeout on the same tick.
			if (complete) begin
				width_cm = ura_pkg::TIMER_W'(echo_ticks / ura_pkg::TICKS_PER_CM_DEF);
				r.sample_cm = (width_cm > ura_pkg::TIMER_W'(range_cfg.max_cm))
					? range_cfg.max_cm : width_cm[ura_pkg::CM_W-1:0];
				r.sample_done = 1'b1;
			end else if (ph_timer >= range_cfg.no_echo_limit) begin
				r.sample_cm = range_cfg.max_cm;
				r.sample_done = 1'b1;
			end
			if (r.sample_done) begin
				echo_armed = 1'b0;
				echo_ticks = '0;
				cm_sum = cm_sum + SUM_W'(r.sample_cm);
				cm_count = cm_count + 1'b1;
				if (cm_count == (1 << ura_pkg::AVERAGE_LOG2_DEF)) begin
					avg_held = cm_sum[SUM_W-1 -: ura_pkg::CM_W];
					cm_sum = '0;
					cm_count = '0;
				end
				ph_timer = '0;
				ph = (range_cfg.settle_ticks == '0) ? ura_pkg::PH_TRIGGER : ura_pkg::PH_SETTLE;
			end
		end
		ura_pkg::PH_SETTLE: begin
			ph_timer = sat_inc(ph_timer);
			if (ph_timer >= range_cfg.settle_ticks) begin
				ph = ura_pkg::PH_TRIGGER;
				ph_timer = '0;
			end
		end
		default: begin
			trig_len = (range_cfg.trigger_ticks == '0) ? ura_pkg::TIMER_W'(1)
				: ura_pkg::TIMER_W'(range_cfg.trigger_ticks);
			r.trigger = 1'b1;
			ph_timer = sat_inc(ph_timer);
			if (ph_timer >= trig_len) begin
				ph = ura_pkg::PH_WAIT;
				ph_timer = '0;
				echo_armed = 1'b0;
				echo_ticks = '0;
			end
		end
		endcase
		echo_prev = e;
		return r;
	endfunction

	// Behaves like a sensor: one echo pulse after each trigger, with some line noise.
	function automatic logic next_echo();
		logic        e;
		int unsigned w;
		e = 1'b0;
		if (ph != ura_pkg::PH_WAIT) begin
			wait_seen = 1'b0;
		end else if (!wait_seen) begin
			wait_seen = 1'b1;
			pulse_fired = 1'b0;
			lead_left = $urandom_range(0, 4);
		end
		if (pulse_left != 0) begin
			pulse_left--;
			e = 1'b1;
		end else begin
			quiet = 1'b0;
			if (wait_seen && !pulse_fired) begin
				if (lead_left != 0) begin
					lead_left--;
				end else begin
					if (long_echo_due) begin
						w = LONG_ECHO_TICKS;
						long_echo_due = 1'b0;
						quiet = 1'b1;
					end else if ($urandom_range(0, 7) == 0) begin
						w = $urandom_range(400, 3000);
					end else begin
						w = $urandom_range(1, 400);
					end
					pulse_fired = 1'b1;
					pulse_left = w - 1;
					e = 1'b1;
				end
			end
		end
		// No noise inside the long pulse, so that it reaches the clamp.
		if (!quiet && $urandom_range(0, 11) == 0) begin
			e = ~e;
		end
		return e;
	endfunction

	function automatic dir_row_t tick_row(logic e, logic rd, bit typed, tick_result_t want);
		dir_row_t row;
		row = '{ROW_TICK, '0, e, rd, typed, want};
		return row;
	endfunction

	function automatic dir_row_t settings_row(ura_pkg::cfg_t s);
		dir_row_t row;
		row = '{ROW_SETTINGS, s, 1'b0, 1'b0, 1'b0, '0};
		return row;
	endfunction

	task automatic send_tick(logic e, logic rd, bit typed, tick_result_t want);
		tick_result_t predicted;
		int           gap;
		in_valid <= 1'b1;
		echo <= e;
		read_request <= rd;
		do @(posedge clk); while (in_stall);
		predicted = ranger_tick(e, rd);
		tick_outputs_due.push_back(typed ? want : predicted);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic put_reg(logic [ura_pkg::CFG_IDX_W-1:0] idx,
		logic [ura_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Registers change only once every transfer in flight has come out.
	task automatic load_settings(ura_pkg::cfg_t s);
		logic [7:0]  pad_trig;
		logic [13:0] pad_cm;
		pad_trig = 8'($urandom);
		pad_cm = 14'($urandom);
		in_valid <= 1'b0;
		do @(posedge clk); while (tick_outputs_due.size() != 0);
		put_reg(ura_pkg::REG_TRIGGER_TICKS, {pad_trig, s.trigger_ticks});
		put_reg(ura_pkg::REG_SETTLE_TICKS, s.settle_ticks);
		put_reg(ura_pkg::REG_NO_ECHO_LIMIT, s.no_echo_limit);
		put_reg(ura_pkg::REG_MAX_CM, {pad_cm, s.max_cm});
		cfg_write <= 1'b0;
		range_cfg = s;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("ultrasonic_range_averager_core_tb NOT OK");
		$finish;
	end

	// Result side: checks each transfer and stalls on its own pattern.
	initial begin
		int           stall_mode;
		int           mode_left;
		int           hold_left;
		logic         stall_next;
		tick_result_t got;
		tick_result_t want;
		stall_mode = 0;
		mode_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {trigger, sample_done, sample_cm, read_valid, read_value};
				if (tick_outputs_due.size() == 0) begin
					bad_ticks++;
					if (bad_ticks <= 10)
						$display("%0t: result with none outstanding: %h", $time, got);
				end else begin
					want = tick_outputs_due.pop_front();
					if (got !== want) begin
						bad_ticks++;
						if (bad_ticks <= 10)
							$display("%0t: exp/act trig %b/%b done %b/%b cm %0d/%0d rv %b/%b val %0d/%0d",
								$time, want.trigger, got.trigger,
								want.sample_done, got.sample_done,
								want.sample_cm, got.sample_cm,
								want.read_valid, got.read_valid,
								want.read_value, got.read_value);
					end
				end
			end
			if (hold_off_req) begin
				hold_left = 400;
				hold_off_req = 1'b0;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (finishing) begin
				stall_next = 1'b0;
			end else begin
				case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 2) == 0);
				2: stall_next = ((mode_left % 5) < 2);
				default: stall_next = ($urandom_range(0, 3) != 0);
				endcase
			end
			out_stall <= stall_next;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		echo <= 1'b0;
		read_request <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= ura_pkg::REG_TRIGGER_TICKS;
		cfg_data <= '0;
		bad_ticks = 0;
		burst_left = 30;
		hold_off_req = 1'b0;
		finishing = 1'b0;
		pulse_left = 0;
		lead_left = 0;
		wait_seen = 1'b0;
		pulse_fired = 1'b0;
		long_echo_due = 1'b0;
		quiet = 1'b0;

		range_cfg = '{ura_pkg::TRIGGER_TICKS_RST, ura_pkg::SETTLE_TICKS_RST,
			ura_pkg::NO_ECHO_LIMIT_RST, ura_pkg::MAX_CM_RST};
		ph = ura_pkg::PH_TRIGGER;
		ph_timer = '0;
		echo_armed = 1'b0;
		echo_ticks = '0;
		echo_prev = 1'b0;
		cm_sum = '0;
		cm_count = '0;
		avg_held = '0;

		// Out of reset: trigger phase, reads of an empty average, echo ignored.
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b1, TRIG_ONLY));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b1, TRIG_ONLY));
		dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b1, TRIG_ONLY));
		// Zero trigger length, zero settle, zero limit and zero clamp.
		dir_rows.push_back(settings_row('0));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b1, TRIG_ONLY));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b1, SAMPLE_ZERO));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b1, TRIG_ONLY));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b0, '0));
		// Echo already high on entry to the wait, then a genuine two-tick echo.
		dir_rows.push_back(settings_row('{16'd1, 24'd2, TIMER_MAX, 10'd1023}));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b0, '0));
		// Falling edge on the very tick the limit is reached.
		dir_rows.push_back(settings_row('{16'd1, 24'd0, 24'd3, 10'd1023}));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, '0));
		dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, '0));

		plan[0] = '{'{16'd2, 24'd3, 24'd300, 10'd5}, 100, 1'b0, 1'b0};
		plan[1] = '{'{16'd1, 24'd0, 24'd1, 10'd1023}, 50, 1'b0, 1'b0};
		plan[2] = '{'{16'd3, 24'd5, TIMER_MAX, 10'd2}, 260, 1'b1, 1'b0};
		plan[3] = '{'{16'd1, TIMER_MAX, 24'd500, 10'd200}, 60, 1'b0, 1'b0};
		plan[4] = '{'{16'hFFFF, 24'd1, 24'd200, 10'd3}, 40, 1'b0, 1'b0};
		plan[5] = '{'{16'd1, 24'd2, 24'd2000, 10'd40}, 100, 1'b0, 1'b1};
		plan[5].settings.trigger_ticks = 16'($urandom_range(1, 3));
		plan[5].settings.settle_ticks = 24'($urandom_range(0, 6));
		plan[5].settings.max_cm = 10'($urandom_range(20, 60));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SETTINGS)
				load_settings(dir_rows[i].settings);
			else
				send_tick(dir_rows[i].echo_level, dir_rows[i].read_req,
					dir_rows[i].typed, dir_rows[i].want);
		end

		foreach (plan[p]) begin
			load_settings(plan[p].settings);
			long_echo_due = plan[p].long_echo;
			if (plan[p].long_echo)
				pulse_left = 0;
			// The sender keeps offering while the result side holds off.
			if (plan[p].hold_off)
				hold_off_req = 1'b1;
			repeat (plan[p].ticks)
				send_tick(next_echo(), ($urandom_range(0, 5) == 0), 1'b0, '0);
		end

		in_valid <= 1'b0;
		finishing = 1'b1;
		while (tick_outputs_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (bad_ticks == 0)
			$display("ultrasonic_range_averager_core_tb OK");
		else
			$display("ultrasonic_range_averager_core_tb NOT OK");
		$finish;
	end

endmodule
